// File: rtl/rfp_pkg.sv
// ============================================================================
// rfp_pkg
// Shared types, constants and the CRC-32 byte update for the route frame
// parser.
// ============================================================================
package rfp_pkg;

   // Frame layout.
   localparam logic [31:0] FRAME_MAGIC = 32'h524F5244;
   localparam int          HDR_LEN     = 16;
   localparam int          SEG_LEN     = 21;
   // Only the first SEG_LEN-1 bytes of a segment record carry fields.
   localparam int          SEG_KEEP    = SEG_LEN - 1;
   localparam int          SEG_OFF_W   = 5;

   // Reflected CRC-32.
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

   // Saturating counters.
   localparam int              POS_W    = 21;
   localparam int              LEN_W    = POS_W + 1;
   localparam int              SEEN_W   = 17;
   localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
   localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

   // Result queue depth (at least 2).
   localparam int RSP_DEPTH = 4;

   // Record kinds.
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_SEGMENT = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;

   // Verdict codes.
   localparam logic [1:0] VERDICT_ACCEPTED = 2'd0;
   localparam logic [1:0] VERDICT_SHORT    = 2'd1;
   localparam logic [1:0] VERDICT_LENGTH   = 2'd2;
   localparam logic [1:0] VERDICT_CRC      = 2'd3;

   // Number of records pushed in one cycle.
   localparam logic [1:0] PUSH_NONE = 2'd0;
   localparam logic [1:0] PUSH_ONE  = 2'd1;
   localparam logic [1:0] PUSH_TWO  = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [1:0]         record_kind;
      logic [15:0]        index_or_version;
      logic [15:0]        start_or_count;
      logic [15:0]        end_point;
      logic [7:0]         type_or_competition;
      logic [7:0]         end_kind_or_hour;
      logic [31:0]        segment_value;
      logic [15:0]        duration_seconds;
      logic [7:0]         jat_or_minute;
      logic signed [15:0] offset_minutes;
      logic [2:0]         presence_flags;
      logic [1:0]         verdict;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    rec0;
      rsp_type    rec1;
   } push_type;

   // One byte through the reflected CRC-32 register, LSB first.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h000000, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

// File: rtl/rfp_parser.sv
// ============================================================================
// rfp_parser
// Frame state, header and segment decode, CRC and verdict for one byte per
// cycle in which step is high. Produces up to two records per byte.
// ============================================================================
module rfp_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  rfp_pkg::req_type  item,
   output rfp_pkg::push_type push
);

   logic [rfp_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [31:0]                   crc_ff, crc_in;
   logic [31:0]                   stored_ff, stored_in;
   logic [15:0]                   version_ff, version_in;
   logic [15:0]                   count_ff, count_in;
   logic [7:0]                    comp_ff, comp_in;
   logic [7:0]                    hour_ff, hour_in;
   logic [7:0]                    minute_ff, minute_in;
   logic [rfp_pkg::SEEN_W-1:0]    seen_ff, seen_in;
   logic                          magic_ff, magic_in;
   logic [rfp_pkg::SEG_OFF_W-1:0] seg_off_ff, seg_off_in;
   logic [7:0]                    seg_ff [rfp_pkg::SEG_KEEP];
   logic [7:0]                    seg_in [rfp_pkg::SEG_KEEP];

   logic                          in_header;
   logic                          seg_store;
   logic                          seg_done;
   logic                          hdr_emit;
   logic                          seg_emit;
   logic [rfp_pkg::LEN_W-1:0]     frame_len;
   logic [rfp_pkg::LEN_W-1:0]     expect_len;
   logic [1:0]                    verdict_code;
   rfp_pkg::rsp_type              rec;
   rfp_pkg::rsp_type              verdict_rec;

   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      stored_in  = stored_ff;
      version_in = version_ff;
      count_in   = count_ff;
      comp_in    = comp_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      seen_in    = seen_ff;
      magic_in   = magic_ff;
      seg_off_in = seg_off_ff;
      seg_in     = seg_ff;

      in_header = pos_ff < rfp_pkg::POS_W'(rfp_pkg::HDR_LEN);
      seg_store = !in_header && (pos_ff != rfp_pkg::POS_MAX);
      seg_done  = seg_store && (seg_off_ff == rfp_pkg::SEG_OFF_W'(rfp_pkg::SEG_LEN - 1));

      if (in_header) begin
         // Header byte offsets: magic, version, count, competition, hour,
         // minute, pad, stored CRC.
         unique case (pos_ff[3:0])
            4'd0, 4'd1, 4'd2, 4'd3: begin
               if (item.data_byte != rfp_pkg::FRAME_MAGIC[8*pos_ff[1:0] +: 8]) begin
                  magic_in = 1'b0;
               end
            end
            4'd4:  version_in[7:0]  = item.data_byte;
            4'd5:  version_in[15:8] = item.data_byte;
            4'd6:  count_in[7:0]    = item.data_byte;
            4'd7:  count_in[15:8]   = item.data_byte;
            4'd8:  comp_in          = item.data_byte;
            4'd9:  hour_in          = item.data_byte;
            4'd10: minute_in        = item.data_byte;
            4'd11: ;
            default: stored_in[8*pos_ff[1:0] +: 8] = item.data_byte;
         endcase
      end else begin
         crc_in = rfp_pkg::crc_byte(crc_ff, item.data_byte);
         if (seg_store) begin
            for (int i = 0; i < rfp_pkg::SEG_KEEP - 1; i++) begin
               seg_in[i] = seg_ff[i+1];
            end
            seg_in[rfp_pkg::SEG_KEEP-1] = item.data_byte;
            seg_off_in = seg_done ? '0 : seg_off_ff + 1'b1;
            if (seg_done && (seen_ff != rfp_pkg::SEEN_MAX)) begin
               seen_in = seen_ff + 1'b1;
            end
         end
      end

      if (pos_ff != rfp_pkg::POS_MAX) begin
         pos_in = pos_ff + 1'b1;
      end

      // Byte 15 of the header never changes the magic flag.
      hdr_emit = in_header && (pos_ff[3:0] == 4'hF) && magic_ff;
      seg_emit = seg_done && magic_ff && (seen_ff < {1'b0, count_ff});

      // When a segment completes, the shift line holds its bytes 0 to 19 in order.
      rec = '0;
      if (hdr_emit) begin
         rec.record_kind         = rfp_pkg::KIND_HEADER;
         rec.index_or_version    = version_ff;
         rec.start_or_count      = count_ff;
         rec.type_or_competition = comp_ff;
         rec.end_kind_or_hour    = hour_ff;
         rec.jat_or_minute       = minute_ff;
      end else begin
         rec.record_kind         = rfp_pkg::KIND_SEGMENT;
         rec.index_or_version    = {seg_ff[1], seg_ff[0]};
         rec.start_or_count      = {seg_ff[3], seg_ff[2]};
         rec.end_point           = {seg_ff[5], seg_ff[4]};
         rec.type_or_competition = seg_ff[6];
         rec.end_kind_or_hour    = seg_ff[7];
         rec.segment_value       = {seg_ff[11], seg_ff[10], seg_ff[9], seg_ff[8]};
         rec.duration_seconds    = {seg_ff[14], seg_ff[13]};
         rec.jat_or_minute       = seg_ff[16];
         rec.offset_minutes      = $signed({seg_ff[19], seg_ff[18]});
         rec.presence_flags      = {seg_ff[17] != 8'h00, seg_ff[15] != 8'h00,
                                    seg_ff[12] != 8'h00};
      end

      // The verdict sees the state as updated by this byte.
      frame_len  = {1'b0, pos_ff} + 1'b1;
      expect_len = rfp_pkg::LEN_W'(rfp_pkg::HDR_LEN)
                 + rfp_pkg::LEN_W'(count_in) * rfp_pkg::LEN_W'(rfp_pkg::SEG_LEN);
      priority if (frame_len < rfp_pkg::LEN_W'(rfp_pkg::HDR_LEN) || !magic_in) begin
         verdict_code = rfp_pkg::VERDICT_SHORT;
      end else if (frame_len != expect_len) begin
         verdict_code = rfp_pkg::VERDICT_LENGTH;
      end else if (stored_in != ~crc_in) begin
         verdict_code = rfp_pkg::VERDICT_CRC;
      end else begin
         verdict_code = rfp_pkg::VERDICT_ACCEPTED;
      end
      verdict_rec             = '0;
      verdict_rec.record_kind = rfp_pkg::KIND_VERDICT;
      verdict_rec.verdict     = verdict_code;

      push.rec1 = verdict_rec;
      push.rec0 = (hdr_emit || seg_emit) ? rec : verdict_rec;
      if (!step) begin
         push.count = rfp_pkg::PUSH_NONE;
      end else if (item.frame_end) begin
         push.count = (hdr_emit || seg_emit) ? rfp_pkg::PUSH_TWO : rfp_pkg::PUSH_ONE;
      end else begin
         push.count = (hdr_emit || seg_emit) ? rfp_pkg::PUSH_ONE : rfp_pkg::PUSH_NONE;
      end

      // The final byte rearms the frame state for the next frame; the segment shift line is not cleared.
      if (item.frame_end) begin
         pos_in     = '0;
         crc_in     = rfp_pkg::CRC_ONES;
         stored_in  = '0;
         version_in = '0;
         count_in   = '0;
         comp_in    = '0;
         hour_in    = '0;
         minute_in  = '0;
         seen_in    = '0;
         magic_in   = 1'b1;
         seg_off_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         crc_ff     <= rfp_pkg::CRC_ONES;
         stored_ff  <= '0;
         version_ff <= '0;
         count_ff   <= '0;
         comp_ff    <= '0;
         hour_ff    <= '0;
         minute_ff  <= '0;
         seen_ff    <= '0;
         magic_ff   <= 1'b1;
         seg_off_ff <= '0;
      end else if (step) begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         stored_ff  <= stored_in;
         version_ff <= version_in;
         count_ff   <= count_in;
         comp_ff    <= comp_in;
         hour_ff    <= hour_in;
         minute_ff  <= minute_in;
         seen_ff    <= seen_in;
         magic_ff   <= magic_in;
         seg_off_ff <= seg_off_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         seg_ff <= seg_in;
      end
   end

endmodule

// File: rtl/rfp_rsp_queue.sv
// ============================================================================
// rfp_rsp_queue
// Small result queue that takes up to two records per cycle and hands out
// one per cycle on the result channel while rsp_stall is low.
// ============================================================================
module rfp_rsp_queue #(
   parameter int DEPTH = rfp_pkg::RSP_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  rfp_pkg::push_type push,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rfp_pkg::rsp_type  rsp_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rfp_pkg::rsp_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_ptr_1;
   logic [PTR_W-1:0]   wr_ptr_2;
   logic               pop;
   logic               put0;
   logic               put1;
   logic [CNT_W-1:0]   push_n;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      // Room for a full pair is required before the parser may take a byte.
      room      = count_ff <= CNT_W'(DEPTH - 2);
      rsp_valid = count_ff != '0;
      rsp_data  = mem_ff[rd_ptr_ff];
      pop       = rsp_valid && !rsp_stall;
      wr_ptr_1  = ptr_next(wr_ptr_ff);
      wr_ptr_2  = ptr_next(wr_ptr_1);

      unique case (push.count)
         rfp_pkg::PUSH_NONE: begin
            put0 = 1'b0;
            put1 = 1'b0;
            wr_ptr_in = wr_ptr_ff;
         end
         rfp_pkg::PUSH_ONE: begin
            put0 = 1'b1;
            put1 = 1'b0;
            wr_ptr_in = wr_ptr_1;
         end
         rfp_pkg::PUSH_TWO: begin
            put0 = 1'b1;
            put1 = 1'b1;
            wr_ptr_in = wr_ptr_2;
         end
         default: begin
            put0 = 1'b0;
            put1 = 1'b0;
            wr_ptr_in = wr_ptr_ff;
         end
      endcase

      push_n    = CNT_W'(put0) + CNT_W'(put1);
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + push_n - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put0) begin
         mem_ff[wr_ptr_ff] <= push.rec0;
      end
      if (put1) begin
         mem_ff[wr_ptr_1] <= push.rec1;
      end
   end

endmodule

// File: rtl/route_frame_parser_crc32.sv
// ============================================================================
// route_frame_parser_crc32
// Streaming parser for a CRC-32 checked binary route frame.
// ============================================================================
// The req channel carries one frame byte per item, with frame_end set on the
// final byte. The rsp channel carries the decoded records: a header record
// once the 16-byte header is in and its magic matched, one segment record per
// completed 21-byte segment (up to the header's segment count), and on the
// final byte a verdict record, which always comes last for the frame.
// Header and segment records are provisional until the verdict arrives.
// An item is registered on acceptance and decoded once the small result queue
// has room for a pair, and its records then enter that queue. One byte is
// accepted every cycle while req_stall is low. A byte that yields two records
// (a completing segment or the header, plus the verdict) occupies two queue
// slots; the queue drains one record per cycle, so the sustained byte rate is
// one per cycle as long as the receiver keeps up. When the receiver stalls,
// the queue fills and req_stall rises once fewer than two free slots remain;
// nothing is lost or reordered.
// Reset empties the queue and input register and rearms the frame state.
// ============================================================================
module route_frame_parser_crc32 #(
   parameter int RSP_DEPTH = rfp_pkg::RSP_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rfp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rfp_pkg::rsp_type rsp_data
);

   logic              in_valid_ff, in_valid_in;
   rfp_pkg::req_type  in_ff;
   logic              room;
   logic              step;
   logic              accept;
   rfp_pkg::push_type push;

   always_comb begin
      step        = in_valid_ff && room;
      req_stall   = in_valid_ff && !room;
      accept      = req_valid && !req_stall;
      in_valid_in = accept || (in_valid_ff && !step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
   end

   rfp_parser u_parser (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_ff),
      .push  (push)
   );

   rfp_rsp_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: verif/testbench.sv
// ============================================================================
// Route frame parser testbench
// Streams route frames byte by byte into route_frame_parser_crc32 and checks
// every header, segment and verdict record it returns. Expected records come
// from a frame decoder kept in this file. The stimulus covers directed frames,
// backpressure and random frames.
// ============================================================================
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FILL_RANDOM  = 0;
   localparam int FILL_ZERO    = 1;
   localparam int FILL_ONES    = 2;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_BYTES = 60;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   rfp_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rfp_pkg::rsp_type rsp_data;

   route_frame_parser_crc32 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Frame decoder state, mirroring what the block keeps for the open frame.
   logic [rfp_pkg::POS_W-1:0]  fr_pos;
   logic [31:0]                fr_crc;
   logic [31:0]                fr_stored;
   logic [55:0]                fr_hdr;
   logic [7:0]                 fr_seg [rfp_pkg::SEG_LEN];
   logic [rfp_pkg::SEEN_W-1:0] fr_seen;
   logic                       fr_magic_ok;

   rfp_pkg::rsp_type pending_records [$];
   logic [7:0]       frame_bytes [$];

   int error_count = 0;
   int frames_sent = 0;
   int bytes_sent = 0;
   int stall_cycles = 0;
   int kind_count [4] = '{0, 0, 0, 0};
   int verdict_count [4] = '{0, 0, 0, 0};

   bit sender_gaps = 1'b0;
   int burst_left = 0;
   bit stall_pattern = 1'b0;
   bit hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("%0t: timeout with %0d records outstanding", $time,
               pending_records.size());
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Queue helpers
   // ------------------------------------------------------------------------
   function automatic void expect_record(input rfp_pkg::rsp_type r);
      pending_records.insert(pending_records.size(), r);
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      frame_bytes.insert(frame_bytes.size(), b);
   endfunction

   // ------------------------------------------------------------------------
   // Frame decoder
   // ------------------------------------------------------------------------
   function automatic logic [31:0] crc32_next(input logic [31:0] c,
                                              input logic [7:0] b);
      logic [31:0] r;
      logic        fb;
      r = c;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ b[i];
         r = r >> 1;
         if (fb) begin
            r = r ^ rfp_pkg::CRC_POLY;
         end
      end
      return r;
   endfunction

   task automatic clear_frame();
      fr_pos = '0;
      fr_crc = rfp_pkg::CRC_ONES;
      fr_stored = '0;
      fr_hdr = '0;
      fr_seen = '0;
      fr_magic_ok = 1'b1;
      for (int i = 0; i < rfp_pkg::SEG_LEN; i++) begin
         fr_seg[i] = 8'h00;
      end
   endtask

   task automatic frame_decode_byte(input logic [7:0] b, input logic last);
      rfp_pkg::rsp_type r;
      int               p;
      int               off;
      int               frame_len;
      p = int'(fr_pos);
      if (p < rfp_pkg::HDR_LEN) begin
         if (p < 4) begin
            if (b != rfp_pkg::FRAME_MAGIC[8*p +: 8]) begin
               fr_magic_ok = 1'b0;
            end
         end else if (p <= 10) begin
            fr_hdr[8*(p-4) +: 8] = b;
         end else if (p >= 12) begin
            fr_stored[8*(p-12) +: 8] = b;
         end
         if (p == rfp_pkg::HDR_LEN - 1 && fr_magic_ok) begin
            r = '0;
            r.record_kind = rfp_pkg::KIND_HEADER;
            r.index_or_version = fr_hdr[15:0];
            r.start_or_count = fr_hdr[31:16];
            r.type_or_competition = fr_hdr[39:32];
            r.end_kind_or_hour = fr_hdr[47:40];
            r.jat_or_minute = fr_hdr[55:48];
            expect_record(r);
         end
      end else begin
         fr_crc = crc32_next(fr_crc, b);
         // Once the byte counter is pinned, segment bytes are no longer kept.
         if (fr_pos < rfp_pkg::POS_MAX) begin
            off = (p - rfp_pkg::HDR_LEN) % rfp_pkg::SEG_LEN;
            fr_seg[off] = b;
            if (off == rfp_pkg::SEG_LEN - 1) begin
               if (fr_magic_ok && fr_seen < fr_hdr[31:16]) begin
                  r = '0;
                  r.record_kind = rfp_pkg::KIND_SEGMENT;
                  r.index_or_version = {fr_seg[1], fr_seg[0]};
                  r.start_or_count = {fr_seg[3], fr_seg[2]};
                  r.end_point = {fr_seg[5], fr_seg[4]};
                  r.type_or_competition = fr_seg[6];
                  r.end_kind_or_hour = fr_seg[7];
                  r.segment_value = {fr_seg[11], fr_seg[10], fr_seg[9], fr_seg[8]};
                  r.duration_seconds = {fr_seg[14], fr_seg[13]};
                  r.jat_or_minute = fr_seg[16];
                  r.offset_minutes = {fr_seg[19], fr_seg[18]};
                  r.presence_flags = {fr_seg[17] != 8'h00, fr_seg[15] != 8'h00,
                                      fr_seg[12] != 8'h00};
                  expect_record(r);
               end
               if (fr_seen < rfp_pkg::SEEN_MAX) begin
                  fr_seen++;
               end
            end
         end
      end
      if (fr_pos < rfp_pkg::POS_MAX) begin
         fr_pos++;
      end
      if (last) begin
         frame_len = p + 1;
         r = '0;
         r.record_kind = rfp_pkg::KIND_VERDICT;
         if (frame_len < rfp_pkg::HDR_LEN || !fr_magic_ok) begin
            r.verdict = rfp_pkg::VERDICT_SHORT;
         end else if (frame_len != rfp_pkg::HDR_LEN
                                   + int'(fr_hdr[31:16]) * rfp_pkg::SEG_LEN) begin
            r.verdict = rfp_pkg::VERDICT_LENGTH;
         end else if (fr_stored != ~fr_crc) begin
            r.verdict = rfp_pkg::VERDICT_CRC;
         end else begin
            r.verdict = rfp_pkg::VERDICT_ACCEPTED;
         end
         expect_record(r);
         clear_frame();
      end
   endtask

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b, input logic last);
      int gap;
      if (sender_gaps) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: b, frame_end: last};
      do @(posedge clock); while (req_stall);
      frame_decode_byte(b, last);
      bytes_sent++;
   endtask

   // Always drops valid before it waits, so a following item
   // never sees two assignments to req_valid in one step.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_records.size() != 0);
   endtask

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(7))
         0, 1:    return 8'h00;
         2:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic build_frame(input logic [15:0] version, input logic [15:0] count,
                              input logic [7:0] comp, input logic [7:0] hour,
                              input logic [7:0] minute, input int nseg, input int fill,
                              input bit crc_good);
      logic [31:0] crc;
      logic [7:0]  b;
      frame_bytes.delete();
      for (int i = 0; i < 4; i++) begin
         add_byte(rfp_pkg::FRAME_MAGIC[8*i +: 8]);
      end
      add_byte(version[7:0]);
      add_byte(version[15:8]);
      add_byte(count[7:0]);
      add_byte(count[15:8]);
      add_byte(comp);
      add_byte(hour);
      add_byte(minute);
      add_byte(8'($urandom_range(255)));
      repeat (4) add_byte(8'h00);
      crc = rfp_pkg::CRC_ONES;
      for (int i = 0; i < nseg * rfp_pkg::SEG_LEN; i++) begin
         if (fill == FILL_ZERO) begin
            b = 8'h00;
         end else if (fill == FILL_ONES) begin
            b = 8'hFF;
         end else begin
            b = rand_byte();
         end
         add_byte(b);
         crc = crc32_next(crc, b);
      end
      crc = ~crc;
      if (!crc_good) begin
         crc = crc ^ (32'h1 << $urandom_range(31));
      end
      for (int i = 0; i < 4; i++) begin
         frame_bytes[12 + i] = crc[8*i +: 8];
      end
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++) begin
         push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
      frames_sent++;
   endtask

   // ------------------------------------------------------------------------
   // Receiver side: random stall windows, or a long hold-off on request.
   // ------------------------------------------------------------------------
   initial begin
      int window;
      int stall_pct;
      int hold_left;
      window = 0;
      stall_pct = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!stall_pattern) begin
            rsp_stall <= 1'b0;
         end else begin
            if (window == 0) begin
               window = $urandom_range(8, 48);
               case ($urandom_range(2))
                  0:       stall_pct = 0;
                  1:       stall_pct = 30;
                  default: stall_pct = 75;
               endcase
            end
            window--;
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Record checker
   // ------------------------------------------------------------------------
   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      error_count++;
   endtask

   task automatic check_record(input rfp_pkg::rsp_type want,
                               input rfp_pkg::rsp_type got);
      if (got.record_kind !== want.record_kind)
         report_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
      if (got.index_or_version !== want.index_or_version)
         report_field("index_or_version", 32'(want.index_or_version),
                      32'(got.index_or_version));
      if (got.start_or_count !== want.start_or_count)
         report_field("start_or_count", 32'(want.start_or_count),
                      32'(got.start_or_count));
      if (got.end_point !== want.end_point)
         report_field("end_point", 32'(want.end_point), 32'(got.end_point));
      if (got.type_or_competition !== want.type_or_competition)
         report_field("type_or_competition", 32'(want.type_or_competition),
                      32'(got.type_or_competition));
      if (got.end_kind_or_hour !== want.end_kind_or_hour)
         report_field("end_kind_or_hour", 32'(want.end_kind_or_hour),
                      32'(got.end_kind_or_hour));
      if (got.segment_value !== want.segment_value)
         report_field("segment_value", want.segment_value, got.segment_value);
      if (got.duration_seconds !== want.duration_seconds)
         report_field("duration_seconds", 32'(want.duration_seconds),
                      32'(got.duration_seconds));
      if (got.jat_or_minute !== want.jat_or_minute)
         report_field("jat_or_minute", 32'(want.jat_or_minute), 32'(got.jat_or_minute));
      if (got.offset_minutes !== want.offset_minutes)
         report_field("offset_minutes", 32'($unsigned(want.offset_minutes)),
                      32'($unsigned(got.offset_minutes)));
      if (got.presence_flags !== want.presence_flags)
         report_field("presence_flags", 32'(want.presence_flags),
                      32'(got.presence_flags));
      if (got.verdict !== want.verdict)
         report_field("verdict", 32'(want.verdict), 32'(got.verdict));
      kind_count[want.record_kind]++;
      if (want.record_kind == rfp_pkg::KIND_VERDICT) begin
         verdict_count[want.verdict]++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall) begin
            stall_cycles++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_records.size() == 0) begin
               $display("%0t: unexpected record, expected none, got %p", $time, rsp_data);
               error_count++;
            end else begin
               check_record(pending_records.pop_front(), rsp_data);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // A header-only frame returns the header record and the verdict on the
   // same byte.
   task automatic test_header_records();
      build_frame(16'hFFFF, 16'd0, 8'hFF, 8'hFF, 8'hFF, 0, FILL_RANDOM, 1'b1);
      send_frame();
      build_frame(16'h0000, 16'd0, 8'h00, 8'h00, 8'h00, 0, FILL_RANDOM, 1'b1);
      send_frame();
   endtask

   task automatic test_segment_records();
      build_frame(16'h8001, 16'd2, 8'h5A, 8'd23, 8'd59, 2, FILL_ONES, 1'b1);
      send_frame();
      build_frame(16'h0001, 16'd1, 8'h01, 8'd0, 8'd0, 1, FILL_ZERO, 1'b1);
      send_frame();
      build_frame(16'($urandom), 16'd3, 8'($urandom), 8'($urandom), 8'($urandom),
                  3, FILL_RANDOM, 1'b1);
      send_frame();
   endtask

   task automatic test_frame_verdicts();
      // One-byte frame and a header cut one byte short.
      push_byte(rfp_pkg::FRAME_MAGIC[7:0], 1'b1);
      frames_sent++;
      build_frame(16'h1234, 16'd0, 8'h01, 8'h02, 8'h03, 0, FILL_RANDOM, 1'b1);
      void'(frame_bytes.pop_back());
      send_frame();
      // A wrong bit in each magic byte.
      for (int k = 0; k < 4; k++) begin
         build_frame(16'h0002, 16'd0, 8'h00, 8'h00, 8'h00, 0, FILL_RANDOM, 1'b1);
         frame_bytes[k] = frame_bytes[k] ^ (8'h01 << $urandom_range(7));
         send_frame();
      end
      // Fewer segments than announced, then more (the extra is not reported).
      build_frame(16'h0003, 16'd2, 8'h00, 8'h00, 8'h00, 1, FILL_RANDOM, 1'b1);
      send_frame();
      build_frame(16'h0004, 16'd1, 8'h00, 8'h00, 8'h00, 2, FILL_RANDOM, 1'b1);
      send_frame();
      build_frame(16'h0005, 16'd1, 8'h00, 8'h00, 8'h00, 1, FILL_RANDOM, 1'b1);
      repeat (5) add_byte(rand_byte());
      send_frame();
      build_frame(16'h0006, 16'd1, 8'h00, 8'h00, 8'h00, 1, FILL_RANDOM, 1'b0);
      send_frame();
   endtask

   // The receiver holds off while one-byte frames keep coming, so the result
   // queue fills and the input stalls.
   task automatic test_output_backpressure();
      sender_gaps = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 24; i++) begin
         push_byte(8'($urandom_range(255)), 1'b1);
         frames_sent++;
      end
      build_frame(16'($urandom), 16'd0, 8'($urandom), 8'($urandom), 8'($urandom),
                  0, FILL_RANDOM, 1'b1);
      send_frame();
      drain();
      sender_gaps = 1'b1;
   endtask

   task automatic send_random_frame();
      int          pick;
      int          nseg;
      int          cut;
      logic [15:0] count;
      pick = $urandom_range(99);
      nseg = $urandom_range(0, 3);
      count = 16'(nseg);
      if (pick >= 60 && pick < 76) begin
         nseg = $urandom_range(0, 3);
         count = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      end
      build_frame(16'($urandom), count, 8'($urandom), 8'($urandom), 8'($urandom),
                  nseg, FILL_RANDOM, !(pick >= 60 && pick < 68));
      if (pick >= 76 && pick < 84) begin
         cut = $urandom_range(1, frame_bytes.size() - 1);
         while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end else if (pick >= 84 && pick < 90) begin
         cut = $urandom_range(3);
         frame_bytes[cut] = frame_bytes[cut] ^ (8'h01 << $urandom_range(7));
      end else if (pick >= 90 && pick < 95) begin
         repeat ($urandom_range(1, 20)) add_byte(rand_byte());
      end else if (pick >= 95) begin
         frame_bytes.delete();
         repeat ($urandom_range(1, 40)) add_byte(8'($urandom_range(255)));
      end
      send_frame();
   endtask

   task automatic test_random_frames();
      int start_bytes;
      sender_gaps = 1'b1;
      stall_pattern = 1'b1;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < RANDOM_BYTES) begin
         send_random_frame();
         if ($urandom_range(5) == 0) begin
            drain();
         end
      end
   endtask

   initial begin
      clear_frame();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      sender_gaps = 1'b1;
      stall_pattern = 1'b1;
      test_header_records();
      test_segment_records();
      test_frame_verdicts();
      test_output_backpressure();
      test_random_frames();
      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d frames in %0d bytes with random gaps, stalls and one long hold-off;",
               frames_sent, bytes_sent);
      $display("checked %0d header, %0d segment, %0d verdict records,",
               kind_count[rfp_pkg::KIND_HEADER], kind_count[rfp_pkg::KIND_SEGMENT],
               kind_count[rfp_pkg::KIND_VERDICT]);
      $display("verdicts accepted/short/length/crc %0d/%0d/%0d/%0d, %0d input stall cycles.",
               verdict_count[rfp_pkg::VERDICT_ACCEPTED],
               verdict_count[rfp_pkg::VERDICT_SHORT],
               verdict_count[rfp_pkg::VERDICT_LENGTH],
               verdict_count[rfp_pkg::VERDICT_CRC], stall_cycles);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
